>>> hw/rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// shared types and constants of the shortest-remaining-time-first scheduler
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int ID_W   = 8;
  localparam int REM_W  = 16;
  localparam int WAIT_W = 32;
  localparam int ORD_W  = 32;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // one task table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [REM_W-1:0]  remaining;
    logic [WAIT_W-1:0] wait_cnt;
    logic [ORD_W-1:0]  order;
  } slot_t;

  // best candidate found so far in a scan
  typedef struct packed {
    logic             vld;
    slot_t            ent;
    logic [ORD_W-1:0] age;
  } cand_t;

  // per-entry controls from the sequencer to the compare unit
  typedef struct packed {
    logic used;      // slot held a task at the start of the tick
    logic ins_here;  // the arriving task lands in this slot
    logic pend_vld;  // last tick's updates still have to be applied
    logic pend_hit;  // this slot ran during the last tick
  } cmp_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/srtf_task_scheduler.sv
// ----------------------------------------------------------------------------
// srtf_task_scheduler
// preemptive shortest-remaining-time-first scheduler, one tick per beat
// ----------------------------------------------------------------------------
//
// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------
// tick in   | start & !busy           | new_valid, new_id, new_burst
// result    | result_strobe (1 cycle) | running_valid, running_id,
//           |                         | running_left, done_valid, done_wait,
//           |                         | all_idle, rejected
//
// per tick, one shared compare unit walks the slot table, one entry per
// cycle through the table's single read port; then ST_LAST finishes the
// scan and ST_OUT shows the result. busy drops during the result cycle,
// so a new beat can be taken there. synchronous reset empties the table
// at once through the per-slot used bits; the result side cannot stall.
//
module srtf_task_scheduler #(
  parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          new_valid,
  input  logic [srtf_pkg::ID_W-1:0]     new_id,
  input  logic [srtf_pkg::REM_W-1:0]    new_burst,
  output logic                          result_strobe,
  output logic                          running_valid,
  output logic [srtf_pkg::ID_W-1:0]     running_id,
  output logic [srtf_pkg::REM_W-1:0]    running_left,
  output logic                          done_valid,
  output logic [srtf_pkg::WAIT_W-1:0]   done_wait,
  output logic                          all_idle,
  output logic                          rejected
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_TASKS);

  srtf_pkg::state_t state, state_next;

  // slot occupancy and bookkeeping
  logic [MAX_TASKS-1:0]        used;
  logic [CNT_W-1:0]            cnt;
  logic [srtf_pkg::ORD_W-1:0]  arrival_count;

  // scan pipeline: read issue, then compare in the following cycle
  logic [IDX_W-1:0]            rd_idx;
  logic                        proc_vld;
  logic [IDX_W-1:0]            proc_idx;

  // pending arrival of the current tick
  logic                        ins_pend;
  srtf_pkg::slot_t             ins_ent;
  logic                        rej_q;

  // winner of the scan
  srtf_pkg::cand_t             best;
  logic [IDX_W-1:0]            best_idx;

  // updates of the last tick, applied lazily during the next scan
  logic                        pend_vld;
  logic [IDX_W-1:0]            pend_sel;

  srtf_pkg::slot_t             rd_ent;
  srtf_pkg::slot_t             upd_ent;
  srtf_pkg::cand_t             cand;
  srtf_pkg::cmp_ctl_t          ctl;
  logic                        take;
  logic                        we;

  logic                        accept;
  logic                        fin;
  logic [CNT_W-1:0]            count_after;
  logic [CNT_W-1:0]            cnt_base;
  logic                        ins_ok;

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srtf_pkg::ST_IDLE: begin
        if (start) state_next = srtf_pkg::ST_SCAN;
      end
      srtf_pkg::ST_SCAN: begin
        if (rd_idx == LAST_IDX) state_next = srtf_pkg::ST_LAST;
      end
      srtf_pkg::ST_LAST: begin
        state_next = srtf_pkg::ST_OUT;
      end
      srtf_pkg::ST_OUT: begin
        state_next = start ? srtf_pkg::ST_SCAN : srtf_pkg::ST_IDLE;
      end
      default: begin
        state_next = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy   = (state == srtf_pkg::ST_SCAN) || (state == srtf_pkg::ST_LAST);
  assign accept = start && !busy;

  // ------------------------------------------------------------------
  // tick result
  // ------------------------------------------------------------------
  // the chosen task finishes when its last tick of work runs now
  assign fin         = best.vld && (best.ent.remaining == srtf_pkg::REM_W'(1));
  assign count_after = cnt - CNT_W'(fin);

  // occupancy seen by a new beat: the finishing task's slot is already free
  assign cnt_base = (state == srtf_pkg::ST_OUT) ? count_after : cnt;
  assign ins_ok   = new_valid && (new_burst != '0) && (cnt_base != FULL_CNT);

  assign result_strobe = (state == srtf_pkg::ST_OUT);
  assign running_valid = best.vld;
  assign running_id    = best.vld ? best.ent.id : '0;
  assign running_left  = best.vld ? (best.ent.remaining - srtf_pkg::REM_W'(1)) : '0;
  assign done_valid    = fin;
  assign done_wait     = fin ? best.ent.wait_cnt : '0;
  assign all_idle      = (count_after == '0);
  assign rejected      = rej_q;

  // ------------------------------------------------------------------
  // table and shared compare unit
  // ------------------------------------------------------------------
  assign ctl.used     = used[proc_idx];
  assign ctl.ins_here = proc_vld && ins_pend && !used[proc_idx];
  assign ctl.pend_vld = pend_vld;
  assign ctl.pend_hit = (proc_idx == pend_sel);

  // write back every live entry so deferred updates land
  assign we = proc_vld && (ctl.used || ctl.ins_here);

  srtf_slot_ram #(
    .DEPTH (MAX_TASKS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (proc_idx),
    .wdata (upd_ent),
    .raddr (rd_idx),
    .rdata (rd_ent)
  );

  srtf_cmp_unit u_cmp (
    .rd_ent        (rd_ent),
    .ins_ent       (ins_ent),
    .ctl           (ctl),
    .arrival_count (arrival_count),
    .best          (best),
    .upd_ent       (upd_ent),
    .cand          (cand),
    .take          (take)
  );

  // ------------------------------------------------------------------
  // datapath and bookkeeping registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      cnt           <= '0;
      arrival_count <= '0;
      rd_idx        <= '0;
      proc_vld      <= 1'b0;
      proc_idx      <= '0;
      ins_pend      <= 1'b0;
      rej_q         <= 1'b0;
      best.vld      <= 1'b0;
      pend_vld      <= 1'b0;
      pend_sel      <= '0;
    end else begin
      proc_vld <= (state == srtf_pkg::ST_SCAN);
      proc_idx <= rd_idx;

      if (state == srtf_pkg::ST_SCAN) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end

      if (proc_vld && take) begin
        best     <= cand;
        best_idx <= proc_idx;
      end

      // arrival takes the lowest free slot, met first in the walk
      if (ctl.ins_here) begin
        used[proc_idx] <= 1'b1;
        ins_pend       <= 1'b0;
      end

      if (state == srtf_pkg::ST_OUT) begin
        pend_vld <= best.vld;
        pend_sel <= best_idx;
        // a beat taken in this cycle sets the count itself
        if (!accept) cnt <= count_after;
        if (fin) used[best_idx] <= 1'b0;
      end

      if (accept) begin
        rd_idx           <= '0;
        best.vld         <= 1'b0;
        rej_q            <= new_valid && !ins_ok;
        ins_pend         <= ins_ok;
        ins_ent.id       <= new_id;
        ins_ent.remaining <= new_burst;
        ins_ent.wait_cnt <= '0;
        ins_ent.order    <= arrival_count;
        cnt              <= cnt_base + CNT_W'(ins_ok);
        if (ins_ok) arrival_count <= arrival_count + srtf_pkg::ORD_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/srtf_slot_ram.sv
// ----------------------------------------------------------------------------
// srtf_slot_ram
// task table storage: one write port, one registered read port
// ----------------------------------------------------------------------------
module srtf_slot_ram #(
  parameter int DEPTH = srtf_pkg::MAX_TASKS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  srtf_pkg::slot_t       wdata,
  input  logic [AW-1:0]         raddr,
  output srtf_pkg::slot_t       rdata
);

  srtf_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/srtf_cmp_unit.sv
// ----------------------------------------------------------------------------
// srtf_cmp_unit
// shared per-entry unit: applies last tick's update and ranks the entry
// ----------------------------------------------------------------------------
module srtf_cmp_unit (
  input  srtf_pkg::slot_t                   rd_ent,
  input  srtf_pkg::slot_t                   ins_ent,
  input  srtf_pkg::cmp_ctl_t                ctl,
  input  logic [srtf_pkg::ORD_W-1:0]        arrival_count,
  input  srtf_pkg::cand_t                   best,
  output srtf_pkg::slot_t                   upd_ent,
  output srtf_pkg::cand_t                   cand,
  output logic                              take
);

  srtf_pkg::slot_t ent;
  logic            present;

  always_comb begin
    ent = rd_ent;
    // deferred update: the task that ran loses one tick, all others wait one more (saturating at WAIT_MAX)
    if (ctl.pend_vld) begin
      if (ctl.pend_hit) begin
        ent.remaining = rd_ent.remaining - srtf_pkg::REM_W'(1);
      end else if (rd_ent.wait_cnt != srtf_pkg::WAIT_MAX) begin
        ent.wait_cnt = rd_ent.wait_cnt + srtf_pkg::WAIT_W'(1);
      end
    end
    if (ctl.ins_here) begin
      ent = ins_ent;
    end
  end

  assign present  = ctl.used || ctl.ins_here;
  assign upd_ent  = ent;
  assign cand.vld = present;
  assign cand.ent = ent;
  assign cand.age = arrival_count - ent.order;

  // least remaining wins, then the older arrival, then the lower slot
  assign take = present &&
                (!best.vld ||
                 (ent.remaining < best.ent.remaining) ||
                 ((ent.remaining == best.ent.remaining) && (cand.age > best.age)));

endmodule
